// ===== rtl/core/ecc_pkg.sv =====
// ---------------------------------------------------------------------------
// ecc_pkg
// shared types, constants and calendar helpers for the epoch calendar unit
// ---------------------------------------------------------------------------
package ecc_pkg;

  localparam int unsigned EPOCH_W  = 32;

  localparam logic [11:0] BASE_YEAR    = 12'd1970;
  localparam logic [11:0] NONLEAP_C1   = 12'd2100;
  localparam logic [11:0] NONLEAP_C2   = 12'd2200;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [16:0] SECS_DAY     = 17'd86400;
  localparam logic [11:0] SECS_HOUR    = 12'd3600;
  localparam logic [5:0]  SECS_MIN     = 6'd60;
  localparam logic [6:0]  DIV_MIN      = 7'd60;
  localparam logic [6:0]  DIV_HOUR     = 7'd60;
  localparam logic [6:0]  DIV_DAY      = 7'd24;
  localparam logic [6:0]  DIV_WEEK     = 7'd7;
  // reciprocals: /60 with shift 37, /24 with shift 36, /7 below 2^16 with shift 19
  localparam logic [31:0] RCP_MIN      = 32'h8888_8889;
  localparam logic [31:0] RCP_DAY      = 32'hAAAA_AAAB;
  localparam logic [31:0] RCP_WEEK     = 32'd74899;
  localparam logic [31:0] WDAY_BIAS    = 32'd4;
  localparam logic [3:0]  LAST_MONTH0  = 4'd11;
  localparam logic [3:0]  MONTH_CLAMP  = 4'd13;
  localparam logic [3:0]  FEB0         = 4'd1;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic {
    CMD_TO_CAL   = 1'b0,
    CMD_TO_EPOCH = 1'b1
  } ecc_cmd_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } ecc_alu_op_t;

  typedef struct packed {
    ecc_alu_op_t op;
    logic [31:0] a;
    logic [31:0] b;
  } ecc_alu_req_t;

  typedef struct packed {
    logic [31:0] y;
    logic        borrow;
  } ecc_alu_rsp_t;

  typedef struct packed {
    logic        command;
    logic [31:0] epoch_seconds;
    logic [5:0]  in_second;
    logic [5:0]  in_minute;
    logic [4:0]  in_hour;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [7:0]  in_year_offset;
  } ecc_in_t;

  typedef struct packed {
    logic [31:0] out_epoch;
    logic [5:0]  out_second;
    logic [5:0]  out_minute;
    logic [4:0]  out_hour;
    logic [2:0]  out_weekday;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [7:0]  out_year_offset;
  } ecc_out_t;

  function automatic logic is_leap(input logic [7:0] off);
    logic [11:0] y;
    y = BASE_YEAR + {4'b0, off};
    return (y[1:0] == 2'b00) && (y != NONLEAP_C1) && (y != NONLEAP_C2);
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] off);
    return is_leap(off) ? DAYS_LEAP : DAYS_COMMON;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m0, input logic [7:0] off);
    logic [4:0] len;
    if (m0 == FEB0) begin
      len = is_leap(off) ? 5'd29 : 5'd28;
    end else if (m0 > LAST_MONTH0) begin
      len = MONTH_LEN[0];
    end else begin
      len = MONTH_LEN[m0];
    end
    return len;
  endfunction

endpackage

// ===== rtl/core/ecc_alu.sv =====
// ---------------------------------------------------------------------------
// ecc_alu
// shared 32-bit add/subtract unit with borrow, used by the sequencer steps that add or subtract
// ---------------------------------------------------------------------------
module ecc_alu
  import ecc_pkg::*;
(
  input  ecc_alu_req_t req,
  output ecc_alu_rsp_t rsp
);

  logic [32:0] sum;

  always_comb begin
    if (req.op == ALU_SUB) begin
      sum = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.y      = sum[31:0];
    rsp.borrow = (req.op == ALU_SUB) && sum[32];
  end

endmodule

// ===== rtl/core/ecc_core.sv =====
// ---------------------------------------------------------------------------
// ecc_core
// sequencer and working registers: reciprocal-multiply constant division,
// year and month walks, and epoch assembly, with adds and subtracts through the shared alu
// ---------------------------------------------------------------------------
module ecc_core
  import ecc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ecc_in_t  item,
  output logic     idle,
  output logic     res_valid,
  input  logic     res_ready,
  output ecc_out_t res
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_WDAY_PREP,
    ST_YEAR,
    ST_MONTH,
    ST_ASM_YEAR,
    ST_ASM_MONTH,
    ST_ASM_DAY,
    ST_ASM_DEC,
    ST_ASM_MUL,
    ST_ASM_HOUR,
    ST_ASM_MIN,
    ST_ASM_SEC,
    ST_FIN
  } state_t;

  state_t       state_r, state_nxt;
  ecc_in_t      in_r, in_nxt;
  logic         cmd_r, cmd_nxt;
  logic [31:0]  acc_r, acc_nxt;
  logic [31:0]  quo_r, quo_nxt;
  logic [31:0]  qt_r, qt_nxt;
  logic [1:0]   phase_r, phase_nxt;
  logic [7:0]   year_r, year_nxt;
  logic [3:0]   mon_r, mon_nxt;
  logic [3:0]   monc_r, monc_nxt;
  logic [5:0]   sec_r, sec_nxt;
  logic [5:0]   min_r, min_nxt;
  logic [4:0]   hour_r, hour_nxt;
  logic [2:0]   wday_r, wday_nxt;

  ecc_alu_req_t alu_req;
  ecc_alu_rsp_t alu_rsp;
  logic [6:0]   divisor;
  logic [31:0]  recip;
  logic [31:0]  quot;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  mul_full;
  logic [16:0]  hour_secs;
  logic [11:0]  min_secs;
  logic [3:0]   mon_inc;

  ecc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign mul_full  = {32'b0, mul_a} * {32'b0, mul_b};
  assign hour_secs = 17'(in_r.in_hour) * 17'(SECS_HOUR);
  assign min_secs  = 12'(in_r.in_minute) * 12'(SECS_MIN);
  assign mon_inc   = mon_r + 4'd1;

  always_comb begin
    unique case (phase_r)
      2'd0: begin
        divisor = DIV_MIN;
        recip   = RCP_MIN;
      end
      2'd1: begin
        divisor = DIV_HOUR;
        recip   = RCP_MIN;
      end
      2'd2: begin
        divisor = DIV_DAY;
        recip   = RCP_DAY;
      end
      default: begin
        divisor = DIV_WEEK;
        recip   = RCP_WEEK;
      end
    endcase
  end

  always_comb begin
    unique case (phase_r)
      2'd0:    quot = {5'b0, mul_full[63:37]};
      2'd1:    quot = {5'b0, mul_full[63:37]};
      2'd2:    quot = {4'b0, mul_full[63:36]};
      default: quot = mul_full[50:19];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    in_nxt    = in_r;
    cmd_nxt   = cmd_r;
    acc_nxt   = acc_r;
    quo_nxt   = quo_r;
    qt_nxt    = qt_r;
    phase_nxt = phase_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    monc_nxt  = monc_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    wday_nxt  = wday_r;
    alu_req.op = ALU_ADD;
    alu_req.a  = acc_r;
    alu_req.b  = 32'd0;
    mul_a      = quo_r;
    mul_b      = recip;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt   = item;
          cmd_nxt  = item.command;
          acc_nxt  = 32'd0;
          year_nxt = 8'd0;
          mon_nxt  = 4'd0;
          if (item.command == CMD_TO_CAL) begin
            quo_nxt   = item.epoch_seconds;
            phase_nxt = 2'd0;
            state_nxt = ST_DIV;
          end else begin
            monc_nxt  = (item.in_month > MONTH_CLAMP) ? MONTH_CLAMP : item.in_month;
            state_nxt = ST_ASM_YEAR;
          end
        end
      end
      ST_DIV: begin
        qt_nxt    = quot;
        state_nxt = ST_REM;
      end
      ST_REM: begin
        mul_a      = qt_r;
        mul_b      = {25'b0, divisor};
        alu_req.op = ALU_SUB;
        alu_req.a  = quo_r;
        alu_req.b  = mul_full[31:0];
        quo_nxt    = qt_r;
        phase_nxt  = phase_r + 2'd1;
        unique case (phase_r)
          2'd0: begin
            sec_nxt   = alu_rsp.y[5:0];
            state_nxt = ST_DIV;
          end
          2'd1: begin
            min_nxt   = alu_rsp.y[5:0];
            state_nxt = ST_DIV;
          end
          2'd2: begin
            hour_nxt  = alu_rsp.y[4:0];
            state_nxt = ST_WDAY_PREP;
          end
          default: begin
            wday_nxt  = alu_rsp.y[2:0] + 3'd1;
            state_nxt = ST_YEAR;
          end
        endcase
      end
      ST_WDAY_PREP: begin
        alu_req.a = quo_r;
        alu_req.b = WDAY_BIAS;
        acc_nxt   = quo_r;
        quo_nxt   = alu_rsp.y;
        state_nxt = ST_DIV;
      end
      ST_YEAR: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = {23'b0, year_len(year_r)};
        if (alu_rsp.borrow) begin
          mon_nxt   = 4'd0;
          state_nxt = ST_MONTH;
        end else begin
          acc_nxt  = alu_rsp.y;
          year_nxt = year_r + 8'd1;
        end
      end
      ST_MONTH: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = {27'b0, month_len(mon_r, year_r)};
        if (mon_r == LAST_MONTH0 || alu_rsp.borrow) begin
          state_nxt = ST_FIN;
        end else begin
          acc_nxt = alu_rsp.y;
          mon_nxt = mon_inc;
        end
      end
      ST_ASM_YEAR: begin
        alu_req.b = {23'b0, year_len(year_r)};
        if (year_r == in_r.in_year_offset) begin
          mon_nxt   = 4'd0;
          state_nxt = ST_ASM_MONTH;
        end else begin
          acc_nxt  = alu_rsp.y;
          year_nxt = year_r + 8'd1;
        end
      end
      ST_ASM_MONTH: begin
        alu_req.b = {27'b0, month_len(mon_r, in_r.in_year_offset)};
        if (mon_inc < monc_r) begin
          acc_nxt = alu_rsp.y;
          mon_nxt = mon_inc;
        end else begin
          state_nxt = ST_ASM_DAY;
        end
      end
      ST_ASM_DAY: begin
        alu_req.b = {27'b0, in_r.in_day};
        acc_nxt   = alu_rsp.y;
        state_nxt = ST_ASM_DEC;
      end
      ST_ASM_DEC: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = 32'd1;
        acc_nxt    = alu_rsp.y;
        state_nxt  = ST_ASM_MUL;
      end
      ST_ASM_MUL: begin
        mul_a     = acc_r;
        mul_b     = {15'b0, SECS_DAY};
        acc_nxt   = mul_full[31:0];
        state_nxt = ST_ASM_HOUR;
      end
      ST_ASM_HOUR: begin
        alu_req.b = {15'b0, hour_secs};
        acc_nxt   = alu_rsp.y;
        state_nxt = ST_ASM_MIN;
      end
      ST_ASM_MIN: begin
        alu_req.b = {20'b0, min_secs};
        acc_nxt   = alu_rsp.y;
        state_nxt = ST_ASM_SEC;
      end
      ST_ASM_SEC: begin
        alu_req.b = {26'b0, in_r.in_second};
        acc_nxt   = alu_rsp.y;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    in_r    <= in_nxt;
    cmd_r   <= cmd_nxt;
    acc_r   <= acc_nxt;
    quo_r   <= quo_nxt;
    qt_r    <= qt_nxt;
    phase_r <= phase_nxt;
    year_r  <= year_nxt;
    mon_r   <= mon_nxt;
    monc_r  <= monc_nxt;
    sec_r   <= sec_nxt;
    min_r   <= min_nxt;
    hour_r  <= hour_nxt;
    wday_r  <= wday_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_FIN);

  always_comb begin
    res = '0;
    if (cmd_r == CMD_TO_EPOCH) begin
      res.out_epoch = acc_r;
    end else begin
      res.out_second      = sec_r;
      res.out_minute      = min_r;
      res.out_hour        = hour_r;
      res.out_weekday     = wday_r;
      res.out_day         = acc_r[4:0] + 5'd1;
      res.out_month       = mon_r + 4'd1;
      res.out_year_offset = year_r;
    end
  end

endmodule

// ===== rtl/core/epoch_calendar_convert_unit.sv =====
// ---------------------------------------------------------------------------
// epoch_calendar_convert_unit
// 32-bit unix epoch to calendar fields and back, one item at a time
// ---------------------------------------------------------------------------
// One item is in work at a time and in_stall stays high until it is done.
// Epoch to calendar splits off second, minute, hour and weekday with four
// reciprocal-multiply divisions, each a multiply step and a remainder step,
// with a weekday bias step before the last, then walks one step per whole
// year past 1970 and one per whole month, each walk with a closing step, and
// hands the result over. Calendar to epoch walks one step per year offset
// and one per preceding month, each with a closing step, then takes seven
// fixed steps. The core returns to idle before it takes the next input
// transfer. Adds and subtracts go through one 32-bit add/subtract unit, the
// division and day products through one shared multiplier. A finished
// result sits in the output register, so the next transfer is accepted while
// the previous result still waits.
module epoch_calendar_convert_unit
  import ecc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ecc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ecc_out_t out_data
);

  logic     core_idle;
  logic     res_valid;
  logic     res_ready;
  ecc_out_t res;
  logic     out_valid_r, out_valid_nxt;
  ecc_out_t out_data_r, out_data_nxt;

  assign in_stall  = ~core_idle;
  assign res_ready = ~out_valid_r | ~out_stall;

  ecc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid & core_idle),
    .item      (in_data),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/ecc_checker.sv =====
// ---------------------------------------------------------------------------
// ecc_checker
// port-level checks on the epoch calendar unit, bound to the top level
// ---------------------------------------------------------------------------
module ecc_checker
  import ecc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input ecc_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input ecc_out_t out_data
);

  // stalled input transfer stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input dropped or changed while stalled");

  // held result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // busy after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // a result is either an epoch or a calendar, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_epoch == 32'd0) || (out_data.out_month == 4'd0))
    else $error("epoch and calendar fields both set");

  // calendar fields in range
  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.out_month != 4'd0) |->
      (out_data.out_month <= 4'd12) && (out_data.out_weekday != 3'd0) &&
      (out_data.out_day != 5'd0) && (out_data.out_second < 6'd60) &&
      (out_data.out_minute < 6'd60) && (out_data.out_hour < 5'd24))
    else $error("calendar field out of range");

endmodule

bind epoch_calendar_convert_unit ecc_checker u_ecc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== bench/epoch_calendar_convert_unit_test.sv =====
// ---------------------------------------------------------------------------
// epoch_calendar_convert_unit_test
// self-checking bench for the epoch / calendar conversion unit: directed
// corner dates and field extremes, then random conversions in both
// directions under varied sender gaps and receiver stalls, each result
// checked field by field against an in-bench calendar computation
// ---------------------------------------------------------------------------
module epoch_calendar_convert_unit_test
  import ecc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned TAIL_CYCLES = 300;

  class calendar_scoreboard;
    ecc_out_t    awaited_results[$];
    int unsigned mismatch_count;
    int unsigned days_per_month[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function new();
      mismatch_count = 0;
    endfunction

    function bit year_is_leap(int unsigned off);
      int unsigned y;
      y = 1970 + off;
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function int unsigned month_days(int unsigned m0, int unsigned off);
      if (m0 == 1) begin
        return year_is_leap(off) ? 29 : 28;
      end
      return days_per_month[m0 % 12];
    endfunction

    function ecc_out_t convert_item(ecc_in_t item);
      ecc_out_t    r;
      bit [31:0]   t;
      bit [31:0]   s;
      bit [31:0]   day;
      int unsigned year;
      int unsigned ylen;
      int unsigned mon;
      int unsigned yoff;
      r = '0;
      if (item.command == CMD_TO_CAL) begin
        t = item.epoch_seconds;
        r.out_second = 6'(t % 60);
        t = t / 60;
        r.out_minute = 6'(t % 60);
        t = t / 60;
        r.out_hour = 5'(t % 24);
        t = t / 24;
        r.out_weekday = 3'(((t + 4) % 7) + 1);
        year = 0;
        forever begin
          ylen = year_is_leap(year) ? 366 : 365;
          if (t < ylen) break;
          t = t - ylen;
          year++;
        end
        for (mon = 0; mon < 11; mon++) begin
          if (t < month_days(mon, year)) break;
          t = t - month_days(mon, year);
        end
        r.out_day = 5'(t + 1);
        r.out_month = 4'(mon + 1);
        r.out_year_offset = 8'(year);
      end else begin
        mon = 32'(item.in_month);
        if (mon > 13) mon = 13;
        yoff = 32'(item.in_year_offset);
        s = 32'(yoff) * 32'd31536000;
        for (int unsigned i = 0; i < yoff; i++) begin
          if (year_is_leap(i)) s = s + 32'd86400;
        end
        for (int unsigned i = 1; i < mon; i++) begin
          s = s + 32'd86400 * 32'(month_days(i - 1, yoff));
        end
        day = 32'(item.in_day) - 32'd1;
        s = s + day * 32'd86400;
        s = s + 32'(item.in_hour) * 32'd3600;
        s = s + 32'(item.in_minute) * 32'd60;
        s = s + 32'(item.in_second);
        r.out_epoch = s;
      end
      return r;
    endfunction

    function void note_request(ecc_in_t item);
      awaited_results.push_back(convert_item(item));
    endfunction

    function void field_check(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
      end
    endfunction

    function void check_result(ecc_out_t got);
      ecc_out_t exp_res;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      exp_res = awaited_results.pop_front();
      field_check("out_epoch", exp_res.out_epoch, got.out_epoch);
      field_check("out_second", 32'(exp_res.out_second), 32'(got.out_second));
      field_check("out_minute", 32'(exp_res.out_minute), 32'(got.out_minute));
      field_check("out_hour", 32'(exp_res.out_hour), 32'(got.out_hour));
      field_check("out_weekday", 32'(exp_res.out_weekday), 32'(got.out_weekday));
      field_check("out_day", 32'(exp_res.out_day), 32'(got.out_day));
      field_check("out_month", 32'(exp_res.out_month), 32'(got.out_month));
      field_check("out_year_offset", 32'(exp_res.out_year_offset),
                  32'(got.out_year_offset));
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ecc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ecc_out_t out_data;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  logic        hold_off;

  calendar_scoreboard board = new();

  epoch_calendar_convert_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic ecc_in_t random_item();
    ecc_in_t     item;
    int unsigned pick;
    item.command        = 1'($urandom_range(1));
    item.epoch_seconds  = $urandom;
    item.in_second      = 6'($urandom_range(63));
    item.in_minute      = 6'($urandom_range(63));
    item.in_hour        = 5'($urandom_range(31));
    item.in_day         = 5'($urandom_range(31));
    item.in_month       = 4'($urandom_range(15));
    item.in_year_offset = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (item.command == CMD_TO_CAL) begin
      if (pick < 15) begin
        item.epoch_seconds = $urandom_range(200_000_000);
      end else if (pick < 25) begin
        item.epoch_seconds = 32'hFFFF_FFFF - $urandom_range(100_000_000);
      end
    end else if (pick < 80) begin
      item.in_second = 6'($urandom_range(59));
      item.in_minute = 6'($urandom_range(59));
      item.in_hour   = 5'($urandom_range(23));
      item.in_day    = 5'($urandom_range(31, 1));
      item.in_month  = 4'($urandom_range(12, 1));
      if (pick < 40) item.in_year_offset = 8'($urandom_range(136));
    end
    return item;
  endfunction

  function automatic ecc_in_t to_cal_item(logic [31:0] epoch);
    ecc_in_t item;
    item = random_item();
    item.command = CMD_TO_CAL;
    item.epoch_seconds = epoch;
    return item;
  endfunction

  function automatic ecc_in_t to_epoch_item(logic [5:0] sec, logic [5:0] min,
                                            logic [4:0] hour, logic [4:0] day,
                                            logic [3:0] mon, logic [7:0] yoff);
    ecc_in_t item;
    item = random_item();
    item.command        = CMD_TO_EPOCH;
    item.in_second      = sec;
    item.in_minute      = min;
    item.in_hour        = hour;
    item.in_day         = day;
    item.in_month       = mon;
    item.in_year_offset = yoff;
    return item;
  endfunction

  task automatic send_item(input ecc_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    board.note_request(item);
  endtask

  task automatic wait_drained();
    while (board.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    ecc_in_t corner_items[$];
    corner_items.push_back(to_cal_item(32'd0));
    corner_items.push_back(to_cal_item(32'hFFFF_FFFF));
    corner_items.push_back(to_cal_item(32'h7FFF_FFFF));
    corner_items.push_back(to_cal_item(32'd31535999));
    corner_items.push_back(to_cal_item(32'd68169600));
    corner_items.push_back(to_cal_item(32'd951782400));
    corner_items.push_back(to_cal_item(32'd951868800));
    corner_items.push_back(to_cal_item(32'd4102444800));
    corner_items.push_back(to_cal_item(32'd4107542400));
    corner_items.push_back(to_epoch_item(6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 8'd0));
    corner_items.push_back(to_epoch_item(6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 8'd136));
    corner_items.push_back(to_epoch_item(6'd63, 6'd63, 5'd31, 5'd31, 4'd15, 8'd255));
    // day zero and month zero
    corner_items.push_back(to_epoch_item(6'd0, 6'd0, 5'd0, 5'd0, 4'd0, 8'd0));
    corner_items.push_back(to_epoch_item(6'd1, 6'd2, 5'd3, 5'd4, 4'd13, 8'd2));
    corner_items.push_back(to_epoch_item(6'd1, 6'd2, 5'd3, 5'd4, 4'd14, 8'd2));
    corner_items.push_back(to_epoch_item(6'd1, 6'd2, 5'd3, 5'd4, 4'd15, 8'd2));
    corner_items.push_back(to_epoch_item(6'd0, 6'd0, 5'd0, 5'd29, 4'd2, 8'd30));
    corner_items.push_back(to_epoch_item(6'd0, 6'd0, 5'd0, 5'd1, 4'd3, 8'd30));
    corner_items.push_back(to_epoch_item(6'd0, 6'd0, 5'd0, 5'd1, 4'd3, 8'd130));
    corner_items.push_back(to_epoch_item(6'd0, 6'd0, 5'd0, 5'd1, 4'd3, 8'd230));
    corner_items.push_back(to_epoch_item(6'd5, 6'd6, 5'd7, 5'd8, 4'd9, 8'd255));
    corner_items.push_back(to_epoch_item(6'd60, 6'd60, 5'd24, 5'd0, 4'd1, 8'd1));
    foreach (corner_items[i]) send_item(corner_items[i]);
    in_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) send_item(random_item());
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering transfers
  task automatic run_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    repeat (8) send_item(random_item());
    in_valid <= 1'b0;
    wait_drained();
    hold_req      = 1'b0;
  endtask

  initial begin
    hold_off = 1'b0;
    forever begin
      wait (hold_req);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
      wait (!hold_req);
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_data);
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_drained();
    run_phase(0, 0, 340);
    run_phase(81, 0, 330);
    run_backpressure();
    run_phase(0, 81, 330);
    run_phase(20, 20, 330);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0 && board.awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ecc_pkg.sv
rtl/core/ecc_alu.sv
rtl/core/ecc_core.sv
rtl/core/epoch_calendar_convert_unit.sv
rtl/core/ecc_checker.sv
bench/epoch_calendar_convert_unit_test.sv
